[sv/rbb_pkg.sv]
// ----------------------------------------------------------------------------
// rbb_pkg: shared types and constants of the RGB444 bitmap blit unit
// Holds the register map, the pixel record that travels from the front end to
// the back end, and the nibble scaling function.
// ----------------------------------------------------------------------------
package rbb_pkg;

  localparam int MAX_DIM     = 32;
  localparam int DIM_W       = 6;
  localparam int COORD_W     = 8;
  localparam int BYTE_W      = 8;
  localparam int NIB_W       = 4;
  localparam int CHAN_W      = 8;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 8;
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    ACT_SET   = 2'd0,
    ACT_CLEAR = 2'd1,
    ACT_KEEP  = 2'd2
  } action_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OFFSET_X      = 3'd0,
    REG_OFFSET_Y      = 3'd1,
    REG_BITMAP_WIDTH  = 3'd2,
    REG_BITMAP_HEIGHT = 3'd3,
    REG_TRANSPARENT   = 3'd4,
    REG_BRIGHTNESS    = 3'd5
  } reg_idx_e;

  // Position of a byte within a three-byte group holding two pixels.
  typedef enum logic [1:0] {
    PH_FIRST  = 2'd0,
    PH_SECOND = 2'd1,
    PH_THIRD  = 2'd2
  } phase_e;

  typedef struct packed {
    logic [COORD_W-1:0] offset_x;
    logic [COORD_W-1:0] offset_y;
    logic [DIM_W-1:0]   width;
    logic [DIM_W-1:0]   height;
    logic               transparent;
    logic [CHAN_W-1:0]  brightness;
  } cfg_t;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [NIB_W-1:0]   r;
    logic [NIB_W-1:0]   g;
    logic [NIB_W-1:0]   b;
    action_e            action;
    logic               last;
  } pix_t;

  // nibble * 17 * brightness >> 8; nibble * 17 is the nibble repeated twice.
  function automatic logic [CHAN_W-1:0] scale(input logic [NIB_W-1:0] nib,
                                              input logic [CHAN_W-1:0] bright);
    logic [2*CHAN_W-1:0] prod;
    prod = {nib, nib} * bright;
    return prod[2*CHAN_W-1:CHAN_W];
  endfunction

endpackage

[sv/rbb_front.sv]
// ----------------------------------------------------------------------------
// rbb_front: byte unpacker and pixel walker
// Splits each three-byte group into two pixels, tracks the column-major walk
// and classifies each pixel as set, clear or keep.
// ----------------------------------------------------------------------------
module rbb_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  rbb_pkg::cfg_t                 cfg_i,
  input  logic                          accept_i,
  input  logic [rbb_pkg::BYTE_W-1:0]    byte_i,
  output logic                          pix_valid_o,
  output rbb_pkg::pix_t                 pix_o
);
  import rbb_pkg::*;

  phase_e              phase_q, phase_d;
  logic [BYTE_W-1:0]   held_first_q, held_first_d;
  logic [NIB_W-1:0]    held_low_q, held_low_d;
  logic [DIM_W-1:0]    col_q, col_d;
  logic [DIM_W-1:0]    row_q, row_d;
  logic                done_q, done_d;

  logic [DIM_W-1:0]    w, h;
  logic                dims_zero;
  logic                row_end, col_end, is_last;
  logic                emit;
  logic [NIB_W-1:0]    nib_r, nib_g, nib_b;

  assign w = (cfg_i.width  > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : cfg_i.width;
  assign h = (cfg_i.height > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : cfg_i.height;
  assign dims_zero = (w == '0) || (h == '0);

  // A counter at or past its bound counts as having reached it.
  assign row_end = ({1'b0, row_q} + (DIM_W+1)'(1)) >= {1'b0, h};
  assign col_end = ({1'b0, col_q} + (DIM_W+1)'(1)) >= {1'b0, w};
  assign is_last = row_end && col_end;

  // Output decode: which bytes form the pixel of this beat.
  always_comb begin
    emit  = 1'b0;
    nib_r = held_first_q[BYTE_W-1:NIB_W];
    nib_g = held_first_q[NIB_W-1:0];
    nib_b = byte_i[BYTE_W-1:NIB_W];
    unique case (phase_q)
      PH_SECOND: begin
        emit = 1'b1;
      end
      PH_THIRD: begin
        emit  = !done_q;
        nib_r = held_low_q;
        nib_g = byte_i[BYTE_W-1:NIB_W];
        nib_b = byte_i[NIB_W-1:0];
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  assign pix_valid_o = accept_i && !dims_zero && emit;

  always_comb begin
    pix_o.x    = cfg_i.offset_x + COORD_W'(col_q);
    pix_o.y    = cfg_i.offset_y + COORD_W'(row_q);
    pix_o.r    = nib_r;
    pix_o.g    = nib_g;
    pix_o.b    = nib_b;
    pix_o.last = is_last;
    if ((nib_r | nib_g | nib_b) != '0) begin
      pix_o.action = ACT_SET;
    end else if (cfg_i.transparent) begin
      pix_o.action = ACT_KEEP;
    end else begin
      pix_o.action = ACT_CLEAR;
    end
  end

  // Next state: byte phase and walk counters.
  always_comb begin
    phase_d      = phase_q;
    held_first_d = held_first_q;
    held_low_d   = held_low_q;
    col_d        = col_q;
    row_d        = row_q;
    done_d       = done_q;
    if (accept_i) begin
      if (dims_zero) begin
        phase_d      = PH_FIRST;
        held_first_d = '0;
        held_low_d   = '0;
        col_d        = '0;
        row_d        = '0;
        done_d       = 1'b0;
      end else begin
        unique case (phase_q)
          PH_SECOND: begin
            held_low_d = byte_i[NIB_W-1:0];
            phase_d    = PH_THIRD;
            done_d     = is_last;
          end
          PH_THIRD: begin
            phase_d = PH_FIRST;
            if (done_q) begin
              held_first_d = '0;
              held_low_d   = '0;
              col_d        = '0;
              row_d        = '0;
              done_d       = 1'b0;
            end
          end
          default: begin
            held_first_d = byte_i;
            phase_d      = PH_SECOND;
            done_d       = 1'b0;
          end
        endcase
        if (emit) begin
          if (is_last) begin
            row_d = '0;
            col_d = '0;
          end else if (row_end) begin
            row_d = '0;
            col_d = col_q + DIM_W'(1);
          end else begin
            row_d = row_q + DIM_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_FIRST;
      held_first_q <= '0;
      held_low_q   <= '0;
      col_q        <= '0;
      row_q        <= '0;
      done_q       <= 1'b0;
    end else begin
      phase_q      <= phase_d;
      held_first_q <= held_first_d;
      held_low_q   <= held_low_d;
      col_q        <= col_d;
      row_q        <= row_d;
      done_q       <= done_d;
    end
  end

endmodule

[sv/rbb_queue.sv]
// ----------------------------------------------------------------------------
// rbb_queue: short pixel queue between front end and back end
// A small circular buffer of pixel records with a registered fill count.
// ----------------------------------------------------------------------------
module rbb_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  rbb_pkg::pix_t pix_i,
  input  logic          pop_i,
  output rbb_pkg::pix_t pix_o,
  output logic          empty_o,
  output logic          full_o
);
  import rbb_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  pix_t             mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == CNT_W'(QUEUE_DEPTH));
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign pix_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= pix_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

[sv/rbb_back.sv]
// ----------------------------------------------------------------------------
// rbb_back: color scaling and result register
// Scales the three nibbles by brightness and holds the finished result until
// it is popped.
// ----------------------------------------------------------------------------
module rbb_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          pix_valid_i,
  input  rbb_pkg::pix_t                 pix_i,
  input  logic [rbb_pkg::CHAN_W-1:0]    brightness_i,
  output logic                          take_o,
  input  logic                          pop_i,
  output logic                          empty_o,
  output logic [rbb_pkg::COORD_W-1:0]   pixel_x_o,
  output logic [rbb_pkg::COORD_W-1:0]   pixel_y_o,
  output logic [rbb_pkg::CHAN_W-1:0]    red_o,
  output logic [rbb_pkg::CHAN_W-1:0]    green_o,
  output logic [rbb_pkg::CHAN_W-1:0]    blue_o,
  output logic [1:0]                    action_o,
  output logic                          last_o
);
  import rbb_pkg::*;

  logic              out_valid_q;
  logic [COORD_W-1:0] x_q, y_q;
  logic [CHAN_W-1:0]  red_q, green_q, blue_q;
  action_e            action_q;
  logic               last_q;

  // The result register refills in the same cycle in which it is popped.
  assign take_o = pix_valid_i && (!out_valid_q || pop_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (take_o) begin
      out_valid_q <= 1'b1;
    end else if (pop_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Zero pixels carry zero nibbles, so clear and keep results scale to zero.
  always_ff @(posedge clk_i) begin
    if (take_o) begin
      x_q      <= pix_i.x;
      y_q      <= pix_i.y;
      red_q    <= scale(pix_i.r, brightness_i);
      green_q  <= scale(pix_i.g, brightness_i);
      blue_q   <= scale(pix_i.b, brightness_i);
      action_q <= pix_i.action;
      last_q   <= pix_i.last;
    end
  end

  assign empty_o   = !out_valid_q;
  assign pixel_x_o = x_q;
  assign pixel_y_o = y_q;
  assign red_o     = red_q;
  assign green_o   = green_q;
  assign blue_o    = blue_q;
  assign action_o  = action_q;
  assign last_o    = last_q;

endmodule

[sv/rgb444_bitmap_blit_unit.sv]
// ----------------------------------------------------------------------------
// rgb444_bitmap_blit_unit: packed RGB444 bitmap unpacker
// A byte that completes a pixel is registered in the pixel queue and then in
// the result register. Throughput: one byte per cycle while full is low; the
// pixel queue absorbs short stalls on pop.
// Reset clears the configuration registers, the walk state, the pixel queue and the result valid flag.
// ----------------------------------------------------------------------------
module rgb444_bitmap_blit_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [rbb_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [rbb_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                             push,
  output logic                             full,
  input  logic [rbb_pkg::BYTE_W-1:0]       data_byte_i,
  input  logic                             pop,
  output logic                             empty,
  output logic [rbb_pkg::COORD_W-1:0]      pixel_x_o,
  output logic [rbb_pkg::COORD_W-1:0]      pixel_y_o,
  output logic [rbb_pkg::CHAN_W-1:0]       red_o,
  output logic [rbb_pkg::CHAN_W-1:0]       green_o,
  output logic [rbb_pkg::CHAN_W-1:0]       blue_o,
  output logic [1:0]                       action_o,
  output logic                             last_o
);
  import rbb_pkg::*;

  // The block is split in two halves. The front end takes one data byte per
  // beat, pairs nibbles into pixels, runs the column-major walk and decides
  // whether each pixel sets, clears or keeps its matrix position. Every beat
  // that completes a pixel pushes one record into a short queue. The back end
  // pulls records out of that queue, scales the three color nibbles by the
  // brightness register and parks the result in an output register that the
  // consumer pops. Either side can stall without stopping the other until the
  // queue fills up.

  cfg_t cfg_q;
  logic accept;
  logic front_valid;
  pix_t front_pix;
  pix_t queue_pix;
  logic queue_empty;
  logic queue_full;
  logic back_take;

  // Configuration registers. Writes to unused indexes are dropped. Software
  // must only write them while no beat is in flight; the block does not check it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_OFFSET_X:      cfg_q.offset_x    <= cfg_data_i[COORD_W-1:0];
        REG_OFFSET_Y:      cfg_q.offset_y    <= cfg_data_i[COORD_W-1:0];
        REG_BITMAP_WIDTH:  cfg_q.width       <= cfg_data_i[DIM_W-1:0];
        REG_BITMAP_HEIGHT: cfg_q.height      <= cfg_data_i[DIM_W-1:0];
        REG_TRANSPARENT:   cfg_q.transparent <= cfg_data_i[0];
        REG_BRIGHTNESS:    cfg_q.brightness  <= cfg_data_i[CHAN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // The input side is full exactly when the pixel queue is full, so a byte
  // that yields a pixel always finds room.
  assign full   = queue_full;
  assign accept = push && !full;

  rbb_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .accept_i    (accept),
    .byte_i      (data_byte_i),
    .pix_valid_o (front_valid),
    .pix_o       (front_pix)
  );

  rbb_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_valid),
    .pix_i   (front_pix),
    .pop_i   (back_take),
    .pix_o   (queue_pix),
    .empty_o (queue_empty),
    .full_o  (queue_full)
  );

  rbb_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pix_valid_i  (!queue_empty),
    .pix_i        (queue_pix),
    .brightness_i (cfg_q.brightness),
    .take_o       (back_take),
    .pop_i        (pop),
    .empty_o      (empty),
    .pixel_x_o    (pixel_x_o),
    .pixel_y_o    (pixel_y_o),
    .red_o        (red_o),
    .green_o      (green_o),
    .blue_o       (blue_o),
    .action_o     (action_o),
    .last_o       (last_o)
  );

endmodule

[sv/rbb_chk.sv]
// ----------------------------------------------------------------------------
// rbb_chk: port-level checks for the RGB444 bitmap blit unit
// Watches the result side and its relation to accepted input beats.
// ----------------------------------------------------------------------------
module rbb_chk (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             push,
  input logic                             full,
  input logic                             pop,
  input logic                             empty,
  input logic [rbb_pkg::COORD_W-1:0]      pixel_x_o,
  input logic [rbb_pkg::COORD_W-1:0]      pixel_y_o,
  input logic [rbb_pkg::CHAN_W-1:0]       red_o,
  input logic [rbb_pkg::CHAN_W-1:0]       green_o,
  input logic [rbb_pkg::CHAN_W-1:0]       blue_o,
  input logic [1:0]                       action_o,
  input logic                             last_o
);
  import rbb_pkg::*;

  // Only the three defined actions ever leave the block.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (action_o == ACT_SET || action_o == ACT_CLEAR || action_o == ACT_KEEP))
    else $error("undefined action code on result");

  // Clear and keep results come from black pixels and carry no color.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && action_o != ACT_SET) |-> (red_o == '0 && green_o == '0 && blue_o == '0))
    else $error("clear or keep result with nonzero color");

  // A result shows only after a taken input beat passed the queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(empty) |-> $past(push && !full, 2))
    else $error("result appeared without a preceding input beat");

  // A waiting result holds until it is popped.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(pixel_x_o) && $stable(pixel_y_o)
                          && $stable(action_o) && $stable(last_o)))
    else $error("stalled result changed");

endmodule

bind rgb444_bitmap_blit_unit rbb_chk u_rbb_chk (.*);
